// ===== src/ttc_pkg.sv =====
// shared types, constants and helpers for the transition/transversion counter
package ttc_pkg;

  localparam int CH_W      = 8;
  localparam int WT_W      = 8;
  localparam int SUM_W     = 28;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int IN_W      = 4 * CH_W;
  localparam int OUT_W     = ((3 * SUM_W + 2 * FRAC_W + 7) / 8) * 8;
  localparam int USER_W    = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CH_W-1:0] CH_A = 8'h41;
  localparam logic [CH_W-1:0] CH_C = 8'h43;
  localparam logic [CH_W-1:0] CH_G = 8'h47;
  localparam logic [CH_W-1:0] CH_T = 8'h54;

  localparam logic [CH_W-1:0] MATCH_CHAR_RST = 8'h2e;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CHAR    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MATCH_ROW = 8'd1;

  // totals of one sequence pair, handed from front to back
  typedef struct packed {
    logic             saturated;
    logic [SUM_W-1:0] transversions;
    logic [SUM_W-1:0] transitions;
    logic [SUM_W-1:0] valid_total;
  } sums_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  function automatic logic is_base(input logic [CH_W-1:0] c);
    return (c == CH_A) || (c == CH_C) || (c == CH_G) || (c == CH_T);
  endfunction

  function automatic logic is_purine(input logic [CH_W-1:0] c);
    return (c == CH_A) || (c == CH_G);
  endfunction

  // top bit flags the clamp, low bits are the clamped sum
  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] sum,
                                             input logic [WT_W-1:0]  w);
    logic [SUM_W:0] t;
    t = {1'b0, sum} + (SUM_W+1)'(w);
    if (t[SUM_W]) begin
      return {1'b1, SUM_MAX};
    end
    return t;
  endfunction

endpackage

// ===== src/transition_transversion_counter_core.sv =====
// top level of the transition/transversion site counter
//
//  channel  dir  signals                          word
//  cfg      in   cfg_valid/ready/index/data       register index, 8-bit value
//  s        in   s_tvalid/tready/tdata/tlast      one aligned site, tlast ends pair
//  m        out  m_tvalid/tready/tdata/tuser      totals and fractions of a pair
//
//  sites are taken one per cycle; the front adds each site's weight in that cycle
//  the back divides one quotient bit per cycle and pops the next pair
//  only after loading the last result into the output register
//  a two-entry queue holds finished pairs; s_tready drops only while it is full
//  reset clears sums and the queue and restores match_char 0x2e, use_match_row 1
module transition_transversion_counter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ttc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // char_a [7:0], char_b [15:8], ref_char [23:16], site_weight [31:24]
  input  logic [ttc_pkg::IN_W-1:0]      s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // valid_total [27:0], transitions [55:28], transversions [83:56],
  // p_fraction [100:84], q_fraction [117:101], zero pad [119:118]
  output logic [ttc_pkg::OUT_W-1:0]     m_tdata,
  // no_valid [0], saturated [1]
  output logic [ttc_pkg::USER_W-1:0]    m_tuser
);
  import ttc_pkg::*;

  sums_t push_data, pop_data;
  logic  push, pop, q_full, q_not_empty;

  assign cfg_ready = 1'b1;

  ttc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ttc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  ttc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

// ===== src/ttc_front.sv =====
// front part: config registers, site classification and weighted sums
module ttc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttc_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ttc_pkg::IN_W-1:0]       s_tdata,
  input  logic                           s_tlast,
  input  logic                           q_full,
  output logic                           push,
  output ttc_pkg::sums_t                 push_data
);
  import ttc_pkg::*;

  logic [CH_W-1:0]  match_char;
  logic             use_match_row;
  logic [SUM_W-1:0] valid_sum;
  logic [SUM_W-1:0] transition_sum;
  logic [SUM_W-1:0] transversion_sum;
  logic             overflow_seen;

  logic [CH_W-1:0]  ca_raw, cb_raw, rc, ca, cb;
  logic [WT_W-1:0]  wt;
  logic             accept;
  logic             counted, same_class, add_ts, add_tv;
  logic [SUM_W:0]   sv, sts, stv;
  sums_t            acc_next;

  assign ca_raw = s_tdata[CH_W-1:0];
  assign cb_raw = s_tdata[2*CH_W-1:CH_W];
  assign rc     = s_tdata[3*CH_W-1:2*CH_W];
  assign wt     = s_tdata[3*CH_W+WT_W-1:3*CH_W];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    ca = ca_raw;
    cb = cb_raw;
    if (use_match_row) begin
      if (ca_raw == match_char) ca = rc;
      if (cb_raw == match_char) cb = rc;
    end
    counted    = (wt != '0) && is_base(ca) && is_base(cb);
    same_class = (is_purine(ca) == is_purine(cb));
    add_ts     = counted && (ca != cb) && same_class;
    add_tv     = counted && (ca != cb) && !same_class;
    sv  = sat_add(valid_sum, wt);
    sts = sat_add(transition_sum, wt);
    stv = sat_add(transversion_sum, wt);

    acc_next.valid_total   = counted ? sv[SUM_W-1:0] : valid_sum;
    acc_next.transitions   = add_ts ? sts[SUM_W-1:0] : transition_sum;
    acc_next.transversions = add_tv ? stv[SUM_W-1:0] : transversion_sum;
    acc_next.saturated     = overflow_seen | (counted & sv[SUM_W]) |
                             (add_ts & sts[SUM_W]) | (add_tv & stv[SUM_W]);
  end

  // the last site's own weight is already in acc_next
  assign push      = accept && s_tlast;
  assign push_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_char    <= MATCH_CHAR_RST;
      use_match_row <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MATCH_CHAR) match_char <= cfg_data;
      if (cfg_index == CFG_USE_MATCH_ROW) use_match_row <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_sum        <= '0;
      transition_sum   <= '0;
      transversion_sum <= '0;
      overflow_seen    <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        valid_sum        <= '0;
        transition_sum   <= '0;
        transversion_sum <= '0;
        overflow_seen    <= 1'b0;
      end else begin
        valid_sum        <= acc_next.valid_total;
        transition_sum   <= acc_next.transitions;
        transversion_sum <= acc_next.transversions;
        overflow_seen    <= acc_next.saturated;
      end
    end
  end

endmodule

// ===== src/ttc_fifo.sv =====
// two-entry queue of pair totals between front and back
module ttc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ttc_pkg::sums_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ttc_pkg::sums_t pop_data
);
  import ttc_pkg::*;

  sums_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// ===== src/ttc_back.sv =====
// back part: fraction division and the result output register
module ttc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_not_empty,
  input  ttc_pkg::sums_t             q_data,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ttc_pkg::OUT_W-1:0]  m_tdata,
  output logic [ttc_pkg::USER_W-1:0] m_tuser
);
  import ttc_pkg::*;

  back_state_t       state, state_next;
  sums_t             work;
  logic [SUM_W:0]    rem_p, rem_q;
  logic [FRAC_W-1:0] quo_p, quo_q;
  logic [STEP_W-1:0] step;

  logic              div_en, load_out, out_free;
  logic [SUM_W:0]    sh_p, sh_q, den_x;
  logic              ge_p, ge_q;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_next = (q_data.valid_total == '0) ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: pop      = q_not_empty;
      BK_DIV:  div_en   = 1'b1;
      BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // restoring division, one quotient bit per cycle for both fractions;
  // remainder stays below the divisor so the shift fits one extra bit
  always_comb begin
    den_x = {1'b0, work.valid_total};
    sh_p  = (step == '0) ? rem_p : {rem_p[SUM_W-1:0], 1'b0};
    sh_q  = (step == '0) ? rem_q : {rem_q[SUM_W-1:0], 1'b0};
    ge_p  = (sh_p >= den_x);
    ge_q  = (sh_q >= den_x);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work  <= q_data;
      rem_p <= {1'b0, q_data.transitions};
      rem_q <= {1'b0, q_data.transversions};
      quo_p <= '0;
      quo_q <= '0;
    end else if (div_en) begin
      rem_p <= ge_p ? sh_p - den_x : sh_p;
      rem_q <= ge_q ? sh_q - den_x : sh_q;
      quo_p <= {quo_p[FRAC_W-2:0], ge_p};
      quo_q <= {quo_q[FRAC_W-2:0], ge_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (pop) step <= '0;
      else if (div_en) step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_W'({quo_q, quo_p, work.transversions, work.transitions,
                         work.valid_total});
      m_tuser <= {work.saturated, (work.valid_total == '0)};
    end
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[3*SUM_W+2*FRAC_W-1:3*SUM_W] == '0 && m_tdata[SUM_W-1:0] == '0))
    else $error("no valid sites but nonzero result");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3*SUM_W+FRAC_W-1:3*SUM_W] <= FRAC_W'(1 << FRAC_BITS)))
    else $error("fraction above one");

  // on the first step the remainder may still equal the divisor
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (work.valid_total != '0 && rem_p <= {1'b0, work.valid_total}))
    else $error("division running with bad divisor or remainder");

endmodule
